// ===== src/bcs_pkg.sv =====
`default_nettype none

package bcs_pkg;

    localparam int PAGE_BITS = 12;
    localparam logic [15:0] MAX_SEGS = 16'd65535;
    localparam int ADDR_W = 4;
    localparam logic [12:0] TABLE_MAX = 13'd4096;

    typedef enum logic [1:0] {
        REG_BLOCK_SHIFT = 2'd0,
        REG_XFER_LIMIT  = 2'd1,
        REG_SEG_TABLE   = 2'd2
    } t_reg_idx;

    // settings as the core sees them
    typedef struct packed {
        logic [4:0]  shift;
        logic [15:0] limit;
        logic [12:0] tsize;
    } t_cfg;

    typedef struct packed {
        logic [23:0] bytes;
        logic        first;
        logic        last;
        logic [62:0] lba;
    } t_seg;

    // max sectors rounded down to whole pages, in blocks:
    // drop every sector bit that sits below the page boundary
    function automatic logic [15:0] f_round_limit(input logic [4:0] sh,
                                                  input logic [15:0] mts);
        logic [15:0] r;
        r = mts;
        for (int i = 0; i < 16; i++) begin
            if (i + int'(sh) < PAGE_BITS) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [12:0] f_table_size(input logic [12:0] t);
        logic [12:0] r;
        if (t == 13'd0) begin
            r = 13'd1;
        end else if (t > TABLE_MAX) begin
            r = TABLE_MAX;
        end else begin
            r = t;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/block_command_splitter.sv =====
`default_nettype none

// Block command splitter: takes one scatter-gather segment beat per cycle and
// returns at most one chunk beat for it (start LBA, block count, first segment
// index, segment count, final flag), or a limit error beat when the
// page-rounded max sector count is zero at the first segment of a command.
// A segment passes from input beat to result beat through the input register,
// then the accumulate-and-compare stage that loads the result register, and
// a new segment is taken every cycle as long as the result side is not
// stalled; a stalled result holds the core, which then stalls the input once
// its input register is full. Registers must be written through the APB port
// only while no segment is in flight; the block itself does not enforce this.
module block_command_splitter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bcs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [23:0]                i_seg_bytes,
    input  wire logic                       i_first_seg,
    input  wire logic                       i_last_seg,
    input  wire logic [62:0]                i_cmd_start_lba,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [62:0]                     o_chunk_lba,
    output logic [31:0]                     o_chunk_blocks,
    output logic [15:0]                     o_chunk_first_index,
    output logic [15:0]                     o_chunk_seg_count,
    output logic                            o_chunk_final,
    output logic                            o_limit_error
);

    bcs_pkg::t_cfg cfg;
    bcs_pkg::t_seg in_seg;
    bcs_pkg::t_seg st_seg;
    logic          st_valid;
    logic          advance;

    assign in_seg.bytes = i_seg_bytes;
    assign in_seg.first = i_first_seg;
    assign in_seg.last  = i_last_seg;
    assign in_seg.lba   = i_cmd_start_lba;

    bcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bcs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_seg     (in_seg),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_seg     (st_seg)
    );

    bcs_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_valid             (st_valid),
        .i_seg               (st_seg),
        .o_advance           (advance),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_chunk_lba         (o_chunk_lba),
        .o_chunk_blocks      (o_chunk_blocks),
        .o_chunk_first_index (o_chunk_first_index),
        .o_chunk_seg_count   (o_chunk_seg_count),
        .o_chunk_final       (o_chunk_final),
        .o_limit_error       (o_limit_error)
    );

endmodule

`default_nettype wire

// ===== src/bcs_cfg.sv =====
`default_nettype none

module bcs_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bcs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output bcs_pkg::t_cfg                   o_cfg
);

    logic [4:0]  r_block_shift;
    logic [15:0] r_xfer_sectors;
    logic [12:0] r_seg_table;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_shift  <= 5'd9;
            r_xfer_sectors <= 16'd1024;
            r_seg_table    <= 13'd128;
        end else if (wr_en) begin
            unique case (reg_sel)
                bcs_pkg::REG_BLOCK_SHIFT: r_block_shift  <= pwdata[4:0];
                bcs_pkg::REG_XFER_LIMIT:  r_xfer_sectors <= pwdata[15:0];
                bcs_pkg::REG_SEG_TABLE:   r_seg_table    <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            bcs_pkg::REG_BLOCK_SHIFT: prdata = {27'd0, r_block_shift};
            bcs_pkg::REG_XFER_LIMIT:  prdata = {16'd0, r_xfer_sectors};
            bcs_pkg::REG_SEG_TABLE:   prdata = {19'd0, r_seg_table};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.shift = r_block_shift;
    assign o_cfg.limit = bcs_pkg::f_round_limit(r_block_shift, r_xfer_sectors);
    assign o_cfg.tsize = bcs_pkg::f_table_size(r_seg_table);

endmodule

`default_nettype wire

// ===== src/bcs_in_stage.sv =====
`default_nettype none

module bcs_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire bcs_pkg::t_seg i_seg,
    input  wire logic          i_advance,
    output logic               o_valid,
    output bcs_pkg::t_seg      o_seg
);

    logic          r_valid;
    bcs_pkg::t_seg r_seg;
    logic          take;

    // holding a beat that the core cannot take yet
    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_seg <= i_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule

`default_nettype wire

// ===== src/bcs_core.sv =====
`default_nettype none

module bcs_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bcs_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    input  wire bcs_pkg::t_seg i_seg,
    output logic               o_advance,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [62:0]        o_chunk_lba,
    output logic [31:0]        o_chunk_blocks,
    output logic [15:0]        o_chunk_first_index,
    output logic [15:0]        o_chunk_seg_count,
    output logic               o_chunk_final,
    output logic               o_limit_error
);

    logic [15:0] r_seg_number, n_seg_number;
    logic [11:0] r_seg_in_table, n_seg_in_table;
    logic [62:0] r_base_lba, n_base_lba;
    logic [31:0] r_done_blocks, n_done_blocks;
    logic [31:0] r_acc_blocks, n_acc_blocks;
    logic [15:0] r_acc_segs, n_acc_segs;
    logic [15:0] r_start_index, n_start_index;
    logic        r_dropped, n_dropped;

    logic        r_out_valid, n_out_valid;
    logic [62:0] r_lba, n_lba;
    logic [31:0] r_blocks, n_blocks;
    logic [15:0] r_first_idx, n_first_idx;
    logic [15:0] r_seg_cnt, n_seg_cnt;
    logic        r_final, n_final;
    logic        r_err, n_err;

    logic [15:0] eff_seg_number;
    logic [11:0] eff_seg_in_table;
    logic [31:0] eff_acc_blocks;
    logic [15:0] eff_acc_segs;
    logic [15:0] eff_start_index;
    logic [31:0] eff_done_blocks;
    logic [31:0] seg_blocks;
    logic [32:0] sum;
    logic [31:0] acc_new;
    logic [16:0] num;
    logic [12:0] sit_inc;
    logic        table_hit;
    logic        is_last;
    logic        close;
    logic        lim_err;
    logic        skip;
    logic [62:0] cur_lba;
    logic        emit;

    assign o_advance = i_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        // a first segment sees a freshly cleared command
        eff_seg_number   = i_seg.first ? 16'd0 : r_seg_number;
        eff_seg_in_table = i_seg.first ? 12'd0 : r_seg_in_table;
        eff_acc_blocks   = i_seg.first ? 32'd0 : r_acc_blocks;
        eff_acc_segs     = i_seg.first ? 16'd0 : r_acc_segs;
        eff_start_index  = i_seg.first ? 16'd0 : r_start_index;
        eff_done_blocks  = i_seg.first ? 32'd0 : r_done_blocks;
        cur_lba          = i_seg.first ? i_seg.lba : (r_base_lba + {31'd0, r_done_blocks});

        seg_blocks = {8'd0, i_seg.bytes >> i_cfg.shift};
        sum        = {1'b0, eff_acc_blocks} + {1'b0, seg_blocks};
        acc_new    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        num        = {1'b0, eff_seg_number} + 17'd1;
        is_last    = i_seg.last || (num >= {1'b0, bcs_pkg::MAX_SEGS});
        sit_inc    = {1'b0, eff_seg_in_table} + 13'd1;
        table_hit  = sit_inc >= i_cfg.tsize;
        close      = table_hit || is_last || (acc_new >= {16'd0, i_cfg.limit});
        lim_err    = i_seg.first && (i_cfg.limit == 16'd0);
        skip       = !i_seg.first && r_dropped;
    end

    always_comb begin
        n_seg_number   = r_seg_number;
        n_seg_in_table = r_seg_in_table;
        n_base_lba     = r_base_lba;
        n_done_blocks  = r_done_blocks;
        n_acc_blocks   = r_acc_blocks;
        n_acc_segs     = r_acc_segs;
        n_start_index  = r_start_index;
        n_dropped      = r_dropped;
        n_lba          = r_lba;
        n_blocks       = r_blocks;
        n_first_idx    = r_first_idx;
        n_seg_cnt      = r_seg_cnt;
        n_final        = r_final;
        n_err          = r_err;
        emit           = 1'b0;

        if (o_advance) begin
            if (i_seg.first) begin
                n_seg_number   = 16'd0;
                n_seg_in_table = 12'd0;
                n_base_lba     = i_seg.lba;
                n_done_blocks  = 32'd0;
                n_acc_blocks   = 32'd0;
                n_acc_segs     = 16'd0;
                n_start_index  = 16'd0;
                n_dropped      = 1'b0;
            end
            if (lim_err) begin
                n_dropped   = 1'b1;
                emit        = 1'b1;
                n_lba       = 63'd0;
                n_blocks    = 32'd0;
                n_first_idx = 16'd0;
                n_seg_cnt   = 16'd0;
                n_final     = 1'b0;
                n_err       = 1'b1;
            end else if (!skip) begin
                n_acc_blocks   = acc_new;
                n_acc_segs     = eff_acc_segs + 16'd1;
                n_seg_number   = num[15:0];
                n_seg_in_table = table_hit ? 12'd0 : sit_inc[11:0];
                if (close) begin
                    emit          = 1'b1;
                    n_lba         = cur_lba;
                    n_blocks      = acc_new;
                    n_first_idx   = eff_start_index;
                    n_seg_cnt     = eff_acc_segs + 16'd1;
                    n_final       = is_last;
                    n_err         = 1'b0;
                    n_done_blocks = eff_done_blocks + acc_new;
                    n_acc_blocks  = 32'd0;
                    n_acc_segs    = 16'd0;
                    n_start_index = num[15:0];
                    if (is_last) begin
                        n_dropped = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        if (o_advance) begin
            n_out_valid = emit;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_number   <= 16'd0;
            r_seg_in_table <= 12'd0;
            r_base_lba     <= 63'd0;
            r_done_blocks  <= 32'd0;
            r_acc_blocks   <= 32'd0;
            r_acc_segs     <= 16'd0;
            r_start_index  <= 16'd0;
            r_dropped      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_seg_number   <= n_seg_number;
            r_seg_in_table <= n_seg_in_table;
            r_base_lba     <= n_base_lba;
            r_done_blocks  <= n_done_blocks;
            r_acc_blocks   <= n_acc_blocks;
            r_acc_segs     <= n_acc_segs;
            r_start_index  <= n_start_index;
            r_dropped      <= n_dropped;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lba       <= n_lba;
        r_blocks    <= n_blocks;
        r_first_idx <= n_first_idx;
        r_seg_cnt   <= n_seg_cnt;
        r_final     <= n_final;
        r_err       <= n_err;
    end

    assign o_out_valid         = r_out_valid;
    assign o_chunk_lba         = r_lba;
    assign o_chunk_blocks      = r_blocks;
    assign o_chunk_first_index = r_first_idx;
    assign o_chunk_seg_count   = r_seg_cnt;
    assign o_chunk_final       = r_final;
    assign o_limit_error       = r_err;

    a_err_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> !r_final)
        else $error("limit error beat marked final");

    a_chunk_has_segs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_err) |-> (r_seg_cnt != 16'd0))
        else $error("chunk with no segments");

    a_final_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_final && !n_err) |=> r_dropped)
        else $error("command still open after final chunk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_advance)
        else $error("core advanced over a stalled result");

endmodule

`default_nettype wire

// ===== dv/tb_block_command_splitter.sv =====
`default_nettype none

module tb_block_command_splitter;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [62:0] lba;
        logic [31:0] blocks;
        logic [15:0] first_idx;
        logic [15:0] seg_cnt;
        logic        is_final;
        logic        lim_err;
    } t_chunk;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [bcs_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    wire  logic [31:0]          prdata;
    wire  logic                 pready;

    logic        in_valid = 1'b0;
    wire  logic  o_in_stall;
    logic [23:0] seg_bytes = '0;
    logic        first_seg = 1'b0;
    logic        last_seg = 1'b0;
    logic [62:0] start_lba = '0;

    wire  logic        o_out_valid;
    logic              out_stall = 1'b0;
    wire  logic [62:0] o_chunk_lba;
    wire  logic [31:0] o_chunk_blocks;
    wire  logic [15:0] o_chunk_first_index;
    wire  logic [15:0] o_chunk_seg_count;
    wire  logic        o_chunk_final;
    wire  logic        o_limit_error;

    block_command_splitter u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_seg_bytes        (seg_bytes),
        .i_first_seg        (first_seg),
        .i_last_seg         (last_seg),
        .i_cmd_start_lba    (start_lba),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_chunk_lba        (o_chunk_lba),
        .o_chunk_blocks     (o_chunk_blocks),
        .o_chunk_first_index(o_chunk_first_index),
        .o_chunk_seg_count  (o_chunk_seg_count),
        .o_chunk_final      (o_chunk_final),
        .o_limit_error      (o_limit_error)
    );

    // pending segments, expected chunks, and run control
    bcs_pkg::t_seg seg_queue[$];
    t_chunk        exp_chunks[$];
    int     err_count = 0;
    int     cycle_count = 0;
    int     idle_in = 37;
    int     stall_pct = 37;
    bit     hold_sender = 1'b0;
    bit     in_taken = 1'b0;

    // register copies
    logic [4:0]  blk_shift = 5'd9;
    logic [15:0] xfer_sectors = 16'd1024;
    logic [12:0] tbl_cfg = 13'd128;

    // splitter state
    logic [15:0] cmd_segs = '0;
    logic [11:0] tbl_pos = '0;
    logic [62:0] cmd_lba = '0;
    logic [31:0] blocks_sent = '0;
    logic [31:0] open_blocks = '0;
    logic [15:0] open_segs = '0;
    logic [15:0] open_first = '0;
    logic        cmd_closed = 1'b0;

    always #2 clk = ~clk;

    task automatic split_segment(input bcs_pkg::t_seg s);
        logic [63:0] lim;
        logic [12:0] tsz;
        logic [32:0] sum;
        logic [16:0] num;
        logic        hit;
        logic        lst;
        t_chunk      c;
        // max transfer in bytes, cut to whole pages, back to blocks
        lim = {48'd0, xfer_sectors} << blk_shift;
        lim = (lim >> bcs_pkg::PAGE_BITS) << bcs_pkg::PAGE_BITS;
        lim = lim >> blk_shift;
        if (tbl_cfg == 13'd0) begin
            tsz = 13'd1;
        end else if (tbl_cfg > bcs_pkg::TABLE_MAX) begin
            tsz = bcs_pkg::TABLE_MAX;
        end else begin
            tsz = tbl_cfg;
        end
        if (s.first) begin
            cmd_segs = '0;
            tbl_pos = '0;
            cmd_lba = s.lba;
            blocks_sent = '0;
            open_blocks = '0;
            open_segs = '0;
            open_first = '0;
            cmd_closed = 1'b0;
            if (lim == 64'd0) begin
                cmd_closed = 1'b1;
                c = '0;
                c.lim_err = 1'b1;
                exp_chunks.push_back(c);
                return;
            end
        end else if (cmd_closed) begin
            return;
        end
        sum = {1'b0, open_blocks} + 33'(s.bytes >> blk_shift);
        open_blocks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        open_segs = open_segs + 16'd1;
        num = {1'b0, cmd_segs} + 17'd1;
        cmd_segs = num[15:0];
        lst = s.last || (num >= {1'b0, bcs_pkg::MAX_SEGS});
        hit = ({1'b0, tbl_pos} + 13'd1) >= tsz;
        tbl_pos = hit ? 12'd0 : tbl_pos + 12'd1;
        if (!(hit || lst || {32'd0, open_blocks} >= lim)) begin
            return;
        end
        c.lba = cmd_lba + {31'd0, blocks_sent};
        c.blocks = open_blocks;
        c.first_idx = open_first;
        c.seg_cnt = open_segs;
        c.is_final = lst;
        c.lim_err = 1'b0;
        exp_chunks.push_back(c);
        blocks_sent = blocks_sent + open_blocks;
        open_blocks = '0;
        open_segs = '0;
        open_first = num[15:0];
        if (lst) begin
            cmd_closed = 1'b1;
        end
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_chunk();
        t_chunk want;
        if (exp_chunks.size() == 0) begin
            $display("%0t: unexpected chunk beat, lba %h blocks %h err %b", $time,
                     o_chunk_lba, o_chunk_blocks, o_limit_error);
            err_count++;
        end else begin
            want = exp_chunks.pop_front();
            cmp_field("chunk_lba", want.lba, o_chunk_lba);
            cmp_field("chunk_blocks", want.blocks, o_chunk_blocks);
            cmp_field("chunk_first_index", want.first_idx, o_chunk_first_index);
            cmp_field("chunk_seg_count", want.seg_cnt, o_chunk_seg_count);
            cmp_field("chunk_final", want.is_final, o_chunk_final);
            cmp_field("limit_error", want.lim_err, o_limit_error);
        end
    endtask

    // input driver: a beat holds until taken
    always @(negedge clk) begin
        bcs_pkg::t_seg nxt;
        if (rst_n && (!in_valid || in_taken)) begin
            if (!hold_sender && seg_queue.size() != 0 && $urandom_range(99) >= idle_in) begin
                nxt = seg_queue.pop_front();
                in_valid <= 1'b1;
                seg_bytes <= nxt.bytes;
                first_seg <= nxt.first;
                last_seg <= nxt.last;
                start_lba <= nxt.lba;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: predicts on taken input beats, checks taken result beats
    always @(posedge clk) begin
        bcs_pkg::t_seg cur;
        in_taken = 1'b0;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                cur.bytes = seg_bytes;
                cur.first = first_seg;
                cur.last = last_seg;
                cur.lba = start_lba;
                split_segment(cur);
            end
            if (o_out_valid && !out_stall) begin
                check_chunk();
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_block_command_splitter: done, errors");
            $finish;
        end
    end

    task automatic apb_cycle(input bcs_pkg::t_reg_idx idx, input logic wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write a register, update the local copy, read it back
    task automatic reg_write(input bcs_pkg::t_reg_idx idx, input logic [31:0] data);
        logic [31:0] stored;
        logic [31:0] rd;
        case (idx)
            bcs_pkg::REG_BLOCK_SHIFT: begin
                blk_shift = data[4:0];
                stored = {27'd0, data[4:0]};
            end
            bcs_pkg::REG_XFER_LIMIT: begin
                xfer_sectors = data[15:0];
                stored = {16'd0, data[15:0]};
            end
            default: begin
                tbl_cfg = data[12:0];
                stored = {19'd0, data[12:0]};
            end
        endcase
        apb_cycle(idx, 1'b1, data, rd);
        apb_cycle(idx, 1'b0, 32'd0, rd);
        if (rd !== stored) begin
            $display("%0t: register %0d readback mismatch, expected %h, got %h",
                     $time, idx, stored, rd);
            err_count++;
        end
    endtask

    task automatic set_config(input logic [31:0] sh, input logic [31:0] mts,
                              input logic [31:0] tsz);
        reg_write(bcs_pkg::REG_BLOCK_SHIFT, sh);
        reg_write(bcs_pkg::REG_XFER_LIMIT, mts);
        reg_write(bcs_pkg::REG_SEG_TABLE, tsz);
    endtask

    // all beats taken, all chunks seen, then let any silent segment drain
    task automatic wait_quiet();
        while (seg_queue.size() != 0 || in_valid || exp_chunks.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_seg(input logic [23:0] b, input logic f, input logic l,
                            input logic [62:0] lba);
        bcs_pkg::t_seg s;
        s.bytes = b;
        s.first = f;
        s.last = l;
        s.lba = lba;
        seg_queue.push_back(s);
    endtask

    function automatic logic [23:0] rand_bytes();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'd0;
            1: v = 32'hFF_FFFF;
            2, 3: v = $urandom;
            4: v = $urandom_range(0, 1023);
            default: v = $urandom_range(1, 16) << blk_shift;
        endcase
        return v[23:0];
    endfunction

    function automatic logic [62:0] rand_lba();
        logic [62:0] v;
        case ($urandom_range(3))
            0: v = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 100000));
            1: v = 63'($urandom_range(0, 1000));
            default: v = 63'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    task automatic push_cmd(input int nsegs, input bit closed);
        for (int i = 0; i < nsegs; i++) begin
            push_seg(rand_bytes(), i == 0, closed && (i == nsegs - 1), rand_lba());
        end
    endtask

    task automatic run_phase(input int n_items, input bit pause_once);
        int pushed;
        int n;
        int r;
        pushed = 0;
        while (pushed < n_items) begin
            r = $urandom_range(99);
            n = ($urandom_range(19) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 12);
            if (r < 80) begin
                push_cmd(n, 1'b1);
            end else if (r < 90) begin
                // left open: the next first segment cuts it off
                push_cmd(n, 1'b0);
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) push_seg(rand_bytes(), 1'b0, 1'($urandom_range(1)), rand_lba());
            end
            pushed += n;
        end
        if (pause_once) begin
            while (seg_queue.size() > pushed / 2) @(negedge clk);
            hold_sender = 1'b1;
            while (in_valid || exp_chunks.size() != 0) @(negedge clk);
            repeat (20) @(negedge clk);
            hold_sender = 1'b0;
        end
        wait_quiet();
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset settings: limit 1024 blocks, table 128
        push_seg(24'd512, 1'b0, 1'b0, 63'h5555);          // no command opened yet
        push_seg(24'd0, 1'b0, 1'b1, 63'h1234);
        push_seg(24'd1024, 1'b0, 1'b0, 63'd7);            // ignored after the final chunk
        push_seg(24'hFF_FFFF, 1'b1, 1'b0, 63'h7FFF_FFFF_FFFF_FFFF);
        push_seg(24'd4096, 1'b0, 1'b0, 63'd0);
        push_seg(24'd511, 1'b1, 1'b1, 63'd0);             // new command cuts the open one
        push_seg(24'hFF_FFFF, 1'b1, 1'b0, 63'h7FFF_FFFF_FFFF_FFF5);
        push_seg(24'hFF_FFFF, 1'b0, 1'b0, 63'd0);         // lba wraps
        push_seg(24'd0, 1'b0, 1'b1, 63'd0);
        wait_quiet();

        // page-rounded limit of zero
        set_config(32'd9, 32'd7, 32'd128);
        push_seg(24'd4096, 1'b1, 1'b0, 63'h42);
        push_seg(24'd4096, 1'b0, 1'b1, 63'h0);
        push_seg(24'd4096, 1'b1, 1'b1, 63'h43);
        wait_quiet();
        reg_write(bcs_pkg::REG_XFER_LIMIT, 32'd8);
        push_seg(24'd4096, 1'b1, 1'b0, 63'h100);
        push_seg(24'd1, 1'b0, 1'b1, 63'h0);
        wait_quiet();
        set_config(32'd16, 32'd0, 32'd128);
        push_seg(24'hFF_FFFF, 1'b1, 1'b1, 63'h200);
        wait_quiet();

        // limit drops to zero in the middle of a command
        set_config(32'd9, 32'd1024, 32'd128);
        push_seg(24'd512, 1'b1, 1'b0, 63'h300);
        wait_quiet();
        reg_write(bcs_pkg::REG_XFER_LIMIT, 32'd0);
        push_seg(24'd0, 1'b0, 1'b0, 63'h0);
        push_seg(24'd1024, 1'b0, 1'b0, 63'h0);
        push_seg(24'd512, 1'b0, 1'b1, 63'h0);
        wait_quiet();

        // table size zero acts as one
        set_config(32'd9, 32'd1024, 32'd0);
        push_seg(24'd512, 1'b1, 1'b0, 63'h400);
        push_seg(24'd512, 1'b0, 1'b0, 63'h0);
        push_seg(24'd512, 1'b0, 1'b1, 63'h0);
        wait_quiet();

        // random phases over a spread of settings
        set_config(32'd9, 32'd1024, 32'd128);
        run_phase(190, 1'b0);
        set_config(32'd12, 32'd65535, 32'd4096);
        run_phase(190, 1'b0);
        set_config(32'd16, 32'd1, 32'd1);
        run_phase(190, 1'b0);
        set_config(32'd0, 32'd65535, 32'd8191);
        run_phase(190, 1'b0);
        idle_in = 0;
        stall_pct = 0;
        set_config(32'd9, 32'd8, 32'd3);
        run_phase(190, 1'b0);
        idle_in = 37;
        stall_pct = 37;
        set_config(32'd31, 32'd100, 32'd0);
        run_phase(190, 1'b0);
        set_config($urandom_range(9, 16), $urandom_range(1, 65535), $urandom_range(1, 16));
        run_phase(190, 1'b0);
        set_config($urandom, $urandom, $urandom);
        run_phase(190, 1'b1);

        // one long command of full-size segments; done_blocks wraps
        set_config(32'd0, 32'd65535, 32'd4096);
        for (int i = 0; i < 260; i++) begin
            push_seg(24'hFF_FFFF - 24'($urandom_range(0, 3)), i == 0, i == 259, rand_lba());
        end
        wait_quiet();

        if (err_count == 0) begin
            $display("tb_block_command_splitter: done, clean");
        end else begin
            $display("tb_block_command_splitter: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/bcs_pkg.sv
src/bcs_cfg.sv
src/bcs_in_stage.sv
src/bcs_core.sv
src/block_command_splitter.sv
dv/tb_block_command_splitter.sv
